>>> src/ccm_pkg.sv
// package for the color digit codeword matcher: constants, control type, color map
`timescale 1ns / 1ps

package ccm_pkg;

  localparam int DigitW        = 3;
  localparam int DigitBase     = 5;
  localparam int ColorCodes    = 32;
  localparam int ColorW        = 5;
  localparam int CharW         = 7;
  localparam int MaxDistW      = 3;
  localparam int CodeDigitsDef = 6;
  localparam int NumCodewordsDef = 128;

  localparam logic [MaxDistW-1:0] MaxDistReset = MaxDistW'(1);
  localparam logic [DigitW-1:0]   DigitUnmapped = DigitW'(1);

  // per-cycle commands to the digit cells
  typedef struct packed {
    logic shift;
    logic clear;
    logic restart;
    logic advance;
  } ccm_ctrl_t;

  function automatic int pow_int(input int base, input int expo);
    int r;
    r = 1;
    for (int k = 0; k < expo; k++) begin
      r = r * base;
    end
    return r;
  endfunction

  function automatic logic [DigitW-1:0] color_digit(input logic [ColorW-1:0] color);
    logic [DigitW-1:0] d;
    d = DigitUnmapped;
    if (int'(color) < ColorCodes) begin
      unique case (color)
        ColorW'(0):  d = DigitW'(3);
        ColorW'(1):  d = DigitW'(2);
        ColorW'(3):  d = DigitW'(0);
        ColorW'(4):  d = DigitW'(0);
        ColorW'(9):  d = DigitW'(4);
        ColorW'(10): d = DigitW'(1);
        default:     d = DigitUnmapped;
      endcase
    end
    return d;
  endfunction

endpackage

>>> src/color_digit_codeword_matcher_top.sv
// top level of the color digit codeword matcher: cell row, scan sequencer, config port
//
// Each accepted color number is mapped to a digit and shifted into a running code held
// in a row of digit cells, one cell per code digit. The same cells then generate the
// codewords one per cycle, while no stalled result holds the output, by adding the fixed
// step digit by digit, and each cycle the digit distance of the running code to the
// current codeword is compared with max_distance. The first codeword within range ends
// the scan, gives found = 1 and its index, and clears the running code; a scan without
// a match gives found = 0 and character = 0. An item is accepted, then its codewords
// are examined in order; one item is in work at a time. The next item is taken while a
// result waits at the output. max_distance sits at byte address 0 of the APB port.
`timescale 1ns / 1ps

module color_digit_codeword_matcher_top
  import ccm_pkg::*;
#(
  parameter int CODE_DIGITS   = CodeDigitsDef,
  parameter int NUM_CODEWORDS = NumCodewordsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ColorW-1:0] color_number_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              found_o,
  output logic [CharW-1:0]  character_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int IdxW    = $clog2(NUM_CODEWORDS);
  localparam int DistW   = $clog2(CODE_DIGITS + 1);
  localparam int CmpW    = (DistW > MaxDistW) ? DistW : MaxDistW;
  localparam int PowTop  = pow_int(DigitBase, CODE_DIGITS);
  localparam int MinVal  = pow_int(DigitBase, CODE_DIGITS - 1);
  localparam int Step    = (PowTop - 1 - MinVal) / NUM_CODEWORDS;
  localparam logic RegMaxDist = 1'b0;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e                state_q;
  logic                  out_valid_q;
  logic                  found_q;
  logic [CharW-1:0]      char_q;
  logic [IdxW-1:0]       idx_q;
  logic [MaxDistW-1:0]   max_dist_q;

  ccm_ctrl_t             ctrl;
  logic                  accept;
  logic                  out_free;
  logic                  match;
  logic                  last;
  logic                  finish;
  logic [DigitW-1:0]     new_digit;
  logic [DigitW-1:0]     run_dig [CODE_DIGITS];
  logic [CODE_DIGITS:0]  carry;
  logic [CODE_DIGITS:0]  run_nz;
  logic [CODE_DIGITS:0]  cw_nz;
  logic [CODE_DIGITS-1:0] diff;
  logic [DistW-1:0]      dist_sum;
  logic [CharW-1:0]      idx_char;
  logic                  cfg_write;

  // config port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == RegMaxDist) ? {{(32 - MaxDistW){1'b0}}, max_dist_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q <= MaxDistReset;
    end else if (cfg_write && (paddr[2] == RegMaxDist)) begin
      max_dist_q <= pwdata[MaxDistW-1:0];
    end
  end

  // cell row
  assign new_digit = color_digit(color_number_i);
  assign carry[0]  = 1'b0;
  assign run_nz[CODE_DIGITS] = 1'b0;
  assign cw_nz[CODE_DIGITS]  = 1'b0;

  for (genvar k = 0; k < CODE_DIGITS; k++) begin : g_cell
    localparam int PowK = pow_int(DigitBase, k);
    localparam logic [DigitW-1:0] StepK = DigitW'((Step / PowK) % DigitBase);
    localparam logic [DigitW-1:0] MinK  = (k == CODE_DIGITS - 1) ? DigitW'(1) : '0;
    logic [DigitW-1:0] shift_in;
    if (k == 0) begin : g_first
      assign shift_in = new_digit;
    end else begin : g_rest
      assign shift_in = run_dig[k-1];
    end
    ccm_cell #(
      .StepDigit(StepK),
      .MinDigit (MinK)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .digit_i (shift_in),
      .digit_o (run_dig[k]),
      .carry_i (carry[k]),
      .carry_o (carry[k+1]),
      .run_nz_i(run_nz[k+1]),
      .cw_nz_i (cw_nz[k+1]),
      .run_nz_o(run_nz[k]),
      .cw_nz_o (cw_nz[k]),
      .diff_o  (diff[k])
    );
  end

  always_comb begin
    dist_sum = '0;
    for (int k = 0; k < CODE_DIGITS; k++) begin
      dist_sum = dist_sum + DistW'(diff[k]);
    end
  end

  for (genvar b = 0; b < CharW; b++) begin : g_char
    if (b < IdxW) begin : g_bit
      assign idx_char[b] = idx_q[b];
    end else begin : g_zero
      assign idx_char[b] = 1'b0;
    end
  end

  // scan control
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign match      = (CmpW'(dist_sum) <= CmpW'(max_dist_q));
  assign last       = (idx_q == IdxW'(NUM_CODEWORDS - 1));
  assign finish     = (state_q == S_SCAN) && out_free && (match || last);

  always_comb begin
    ctrl.shift   = accept;
    ctrl.restart = accept;
    ctrl.clear   = (state_q == S_SCAN) && out_free && match;
    ctrl.advance = (state_q == S_SCAN) && out_free && !match && !last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      char_q      <= '0;
      idx_q       <= '0;
    end else begin
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_SCAN;
            idx_q   <= '0;
          end
        end
        S_SCAN: begin
          if (finish) begin
            found_q     <= match;
            char_q      <= match ? idx_char : '0;
            state_q     <= S_IDLE;
          end else if (ctrl.advance) begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign character_o = char_q;

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_SCAN) && (idx_q == '0))
    else $error("accepted transfer did not start a scan");

  a_no_match_zero_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (character_o == '0))
    else $error("character set without a match");

  a_clear_empties_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clear |=> !run_nz[0])
    else $error("running code not cleared after match");

  a_finish_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(found_o) && $stable(character_o))
    else $error("result overwritten while output stalled");

endmodule

>>> src/ccm_cell.sv
// one digit cell: running digit, codeword digit, step adder and distance term
`timescale 1ns / 1ps

module ccm_cell
  import ccm_pkg::*;
#(
  parameter logic [DigitW-1:0] StepDigit = '0,
  parameter logic [DigitW-1:0] MinDigit  = '0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ccm_ctrl_t         ctrl_i,
  input  logic [DigitW-1:0] digit_i,
  output logic [DigitW-1:0] digit_o,
  input  logic              carry_i,
  output logic              carry_o,
  input  logic              run_nz_i,
  input  logic              cw_nz_i,
  output logic              run_nz_o,
  output logic              cw_nz_o,
  output logic              diff_o
);

  logic [DigitW-1:0] run_q, run_d;
  logic [DigitW-1:0] cw_q, cw_d;
  logic [DigitW:0]   sum;
  logic [DigitW:0]   wrapped;

  assign sum     = {1'b0, cw_q} + {1'b0, StepDigit} + {{DigitW{1'b0}}, carry_i};
  assign carry_o = (int'(sum) >= DigitBase);
  assign wrapped = sum - (DigitW + 1)'(DigitBase);

  assign run_nz_o = run_nz_i | (run_q != '0);
  assign cw_nz_o  = cw_nz_i | (cw_q != '0);
  assign diff_o   = (run_nz_o && cw_nz_o) ? (run_q != cw_q) : (run_nz_o || cw_nz_o);
  assign digit_o  = run_q;

  always_comb begin
    run_d = run_q;
    if (ctrl_i.clear) begin
      run_d = '0;
    end else if (ctrl_i.shift) begin
      run_d = digit_i;
    end
    cw_d = cw_q;
    if (ctrl_i.restart) begin
      cw_d = MinDigit;
    end else if (ctrl_i.advance) begin
      cw_d = carry_o ? wrapped[DigitW-1:0] : sum[DigitW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
      cw_q  <= MinDigit;
    end else begin
      run_q <= run_d;
      cw_q  <= cw_d;
    end
  end

endmodule
